[rtl/assert_macros.svh]
// assertion helpers, clocked on clock and held off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPPS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpps assertion failed");

// next-cycle implication
`define LPPS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpps assertion failed");

`endif

[rtl/lpps_pkg.sv]
`timescale 1ns / 1ps

package lpps_pkg;

   // sizes of the string, the alphabet and the mask table
   localparam int MAX_LEN   = 1024;
   localparam int ALPHABET  = 26;
   localparam int LETTER_W  = 5;
   localparam int MASK_W    = ALPHABET;
   localparam int POS_W     = $clog2(MAX_LEN + 1);
   localparam int TBL_DEPTH = MAX_LEN + 1;
   localparam int IDX_W     = $clog2(TBL_DEPTH);
   localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

   // one table entry: a parity mask and the first prefix position it was seen
   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [POS_W-1:0]  pos;
   } entry_type;

   // write port of the table
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

   // result of one entry compare
   typedef struct packed {
      logic             equal;
      logic             better;
      logic [POS_W-1:0] len;
   } cmp_res_type;

endpackage

[rtl/lpps_table.sv]
`timescale 1ns / 1ps

module lpps_table (
   input  logic                          clock,
   input  lpps_pkg::tbl_wr_type          wr,
   input  logic                          rd_en,
   input  logic [lpps_pkg::IDX_W-1:0]    rd_addr,
   output lpps_pkg::entry_type           rd_data
);
   import lpps_pkg::*;

   entry_type mem [TBL_DEPTH];
   entry_type rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lpps_cmp.sv]
`timescale 1ns / 1ps

module lpps_cmp (
   input  lpps_pkg::entry_type            entry,
   input  logic [lpps_pkg::MASK_W-1:0]    cur_mask,
   input  logic [lpps_pkg::POS_W-1:0]     cur_pos,
   input  logic [lpps_pkg::POS_W-1:0]     best,
   output lpps_pkg::cmp_res_type          res
);
   import lpps_pkg::*;

   logic [MASK_W-1:0] diff;
   logic              one_bit;

   // masks within one bit of each other: diff has at most one bit set
   assign diff    = entry.mask ^ cur_mask;
   assign one_bit = ((diff & (diff - MASK_W'(1))) == '0);

   // substring length from the first sighting, stored positions never pass cur_pos
   always_comb begin
      res.equal  = (diff == '0);
      res.len    = cur_pos - entry.pos;
      res.better = one_bit && (res.len > best);
   end

endmodule

[rtl/longest_palindrome_permutation_substring.sv]
`timescale 1ns / 1ps
// channel | ports                           | direction
// --------+---------------------------------+----------
// req     | req_valid/ready, letter, start  | in
// rsp     | rsp_valid/ready, best, too_long | out
//
// a letter scans the table: it has one read port and every stored mask is
// read and compared once, one per cycle.
// an ignored letter (too long or out of range) skips the scan.
// reset is synchronous; the table needs no clearing, only entries below the
// fill count are read and entry 0 is the fixed zero mask at position zero.
// req_ready is low while a word is worked on; a stalled rsp holds its word.

`include "assert_macros.svh"

module longest_palindrome_permutation_substring (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lpps_pkg::LETTER_W-1:0]    req_letter,
   input  logic                             req_start_req,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lpps_pkg::POS_W-1:0]       rsp_best_length,
   output logic                             rsp_too_long
);
   import lpps_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  best_ff, best_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              found_ff, found_in;
   logic              flag_ff, flag_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              cmp_zero_ff, cmp_zero_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_best_ff, rsp_best_in;
   logic              rsp_flag_ff, rsp_flag_in;

   logic              accept;
   logic              letter_ok;
   logic [MASK_W-1:0] base_mask;
   logic [POS_W-1:0]  base_pos;
   logic [POS_W-1:0]  base_best;
   logic [CNT_W-1:0]  base_count;
   logic              issue;
   logic              scan_end;
   logic              post;
   tbl_wr_type        wr;
   entry_type         rd_data;
   entry_type         cmp_entry;
   cmp_res_type       cmp_res;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign letter_ok = (int'(req_letter) < ALPHABET);

   // a start request clears the state before the letter is applied
   assign base_mask  = req_start_req ? '0 : mask_ff;
   assign base_pos   = req_start_req ? '0 : pos_ff;
   assign base_best  = req_start_req ? '0 : best_ff;
   assign base_count = req_start_req ? CNT_W'(1) : count_ff;

   // scan issue and end of scan
   assign issue    = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign scan_end = (state_ff == ST_SCAN) && !issue && !cmp_valid_ff;
   assign post     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // entry 0 is the fixed zero mask at position zero
   assign cmp_entry = cmp_zero_ff ? '0 : rd_data;

   lpps_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   lpps_cmp u_cmp (
      .entry    (cmp_entry),
      .cur_mask (mask_ff),
      .cur_pos  (pos_ff),
      .best     (best_ff),
      .res      (cmp_res)
   );

   // insert a new mask at the fill count once the scan found no match
   always_comb begin
      wr.en        = scan_end && !found_ff && (count_ff < CNT_W'(TBL_DEPTH));
      wr.addr      = count_ff[IDX_W-1:0];
      wr.data.mask = mask_ff;
      wr.data.pos  = pos_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      flag_in      = flag_ff;
      cmp_valid_in = 1'b0;
      cmp_zero_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mask_in  = base_mask;
               pos_in   = base_pos;
               best_in  = base_best;
               count_in = base_count;
               flag_in  = 1'b0;
               if (base_pos >= POS_W'(MAX_LEN)) begin
                  flag_in  = 1'b1;
                  state_in = ST_DONE;
               end else if (letter_ok) begin
                  mask_in   = base_mask ^ (MASK_W'(1) << req_letter);
                  pos_in    = base_pos + POS_W'(1);
                  found_in  = 1'b0;
                  rd_idx_in = '0;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
               cmp_zero_in  = (rd_idx_ff == '0);
            end
            if (cmp_valid_ff) begin
               if (cmp_res.equal) begin
                  found_in = 1'b1;
               end
               if (cmp_res.better) begin
                  best_in = cmp_res.len;
               end
            end
            if (scan_end) begin
               if (wr.en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (post) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (post) begin
         rsp_valid_in = 1'b1;
         rsp_best_in  = best_ff;
         rsp_flag_in  = flag_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
         count_ff     <= CNT_W'(1);
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
         best_ff      <= best_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      found_ff    <= found_in;
      flag_ff     <= flag_in;
      cmp_zero_ff <= cmp_zero_in;
      rsp_best_ff <= rsp_best_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = rsp_best_ff;
   assign rsp_too_long    = rsp_flag_ff;

   // fill count stays within the table and never drops below the zero entry
   `LPPS_ASSERT_NOW(a_count_range, 1'b1, (count_ff >= CNT_W'(1)) && (count_ff <= CNT_W'(TBL_DEPTH)))
   // best length can never exceed the current position
   `LPPS_ASSERT_NOW(a_best_le_pos, 1'b1, best_ff <= pos_ff)
   // an insert at the end of a scan grows the fill count by one
   `LPPS_ASSERT_NEXT(a_insert_count, wr.en, count_ff == $past(count_ff) + CNT_W'(1))
   // compares only happen while scanning
   `LPPS_ASSERT_NOW(a_cmp_in_scan, cmp_valid_ff, state_ff == ST_SCAN)

endmodule
